// ----- hdl/cpa_pkg.sv -----
// Shared types and constants of the contiguous page allocator.
// No dependencies; used by cpa_div, cpa_cell and the top level.
`timescale 1ns / 1ps
`default_nettype none

package cpa_pkg;

	// Page map size and the index/count widths that follow from it
	localparam int MAX_PAGES = 64;
	localparam int IDX_W     = $clog2(MAX_PAGES);
	localparam int CNT_W     = $clog2(MAX_PAGES + 1);

	// Field widths
	localparam int TIME_W  = 16;
	localparam int OWNER_W = 16;
	localparam int BYTES_W = 18;
	localparam int PSIZE_W = 13;
	localparam int PUSE_W  = 7;
	localparam int FIRST_W = 6;
	localparam int COUNT_W = 7;

	// Divider: dividend is bytes + page size - 1
	localparam int DVD_W   = BYTES_W + 1;
	localparam int STEP_W  = $clog2(DVD_W + 1);

	// Register reset values and byte addresses
	localparam logic [PSIZE_W-1:0] PG_SIZE_RST      = PSIZE_W'(100);
	localparam logic [PUSE_W-1:0]  PAGES_IN_USE_RST = PUSE_W'(64);
	localparam int ADDR_W = 3;
	localparam logic REG_PG_SIZE      = 1'b0;
	localparam logic REG_PAGES_IN_USE = 1'b1;

	// Input kinds carried on tuser
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_ALLOC = 1'b1;

	// Data handed from one cell to the next during a scan
	typedef struct packed {
		logic             tok;
		logic [CNT_W-1:0] run;
		logic             found;
		logic [IDX_W-1:0] end_idx;
	} link_t;

	// Broadcast controls from the sequencer to every cell
	typedef struct packed {
		logic               tick_en;
		logic [TIME_W-1:0]  now;
		logic               mark_en;
		logic [IDX_W-1:0]   mark_first;
		logic [IDX_W-1:0]   mark_last;
		logic [OWNER_W-1:0] owner;
		logic [TIME_W-1:0]  rel;
		logic [CNT_W-1:0]   need;
		logic [CNT_W-1:0]   limit;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/cpa_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on cpa_pkg for the dividend and divisor widths.
`timescale 1ns / 1ps
`default_nettype none

module cpa_div import cpa_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [DVD_W-1:0]   dividend,
	input  wire logic [PSIZE_W-1:0] divisor,
	output logic                    done,
	output logic [DVD_W-1:0]        quotient
);

	logic               busy_q;
	logic               done_q;
	logic [STEP_W-1:0]  cnt_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [PSIZE_W-1:0] rem_q;
	logic [PSIZE_W-1:0] dvr_q;
	logic [PSIZE_W:0]   trial;
	logic               qbit;

	// Shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign qbit  = (trial >= {1'b0, dvr_q});

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? PSIZE_W'(trial - {1'b0, dvr_q}) : PSIZE_W'(trial);
			dvd_q <= {dvd_q[DVD_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

`default_nettype wire

// ----- hdl/cpa_cell.sv -----
// One page of the map: free mark, release time, owner and a scan stage.
// Depends on cpa_pkg for link_t and cell_ctl_t.
`timescale 1ns / 1ps
`default_nettype none

module cpa_cell import cpa_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IDX_W-1:0] idx,
	input  wire cell_ctl_t        ctl,
	input  wire link_t            link_in,
	output link_t                 link_out
);

	logic               free_q;
	logic [TIME_W-1:0]  rel_q;
	logic [OWNER_W-1:0] owner_q;
	logic               tok_q;
	logic               found_q;
	logic [CNT_W-1:0]   run_q;
	logic [IDX_W-1:0]   end_q;

	logic             hit;
	logic             in_range;
	logic [CNT_W-1:0] run_next;

	assign hit      = (idx >= ctl.mark_first) && (idx <= ctl.mark_last);
	assign in_range = (CNT_W'(idx) < ctl.limit);

	// Extend the free run, break it on a taken or unmanaged page or once found
	assign run_next = (!link_in.found && free_q && in_range) ?
		link_in.run + CNT_W'(1) : '0;

	// Free on a matching tick, take on a mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= 1'b1;
		end else if (ctl.tick_en && !free_q && rel_q == ctl.now) begin
			free_q <= 1'b1;
		end else if (ctl.mark_en && hit) begin
			free_q <= 1'b0;
		end
	end

	// Record the page's owner and release time
	always_ff @(posedge clk) begin
		if (ctl.mark_en && hit) begin
			rel_q   <= ctl.rel;
			owner_q <= ctl.owner;
		end
	end

	// Pass the scan token and its flags on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= 1'b0;
			found_q <= 1'b0;
		end else begin
			tok_q <= link_in.tok;
			if (link_in.tok) begin
				found_q <= link_in.found || (run_next == ctl.need);
			end
		end
	end

	// Scan payload
	always_ff @(posedge clk) begin
		if (link_in.tok) begin
			run_q <= run_next;
			end_q <= link_in.found ? link_in.end_idx : idx;
		end
	end

	assign link_out.tok     = tok_q;
	assign link_out.run     = run_q;
	assign link_out.found   = found_q;
	assign link_out.end_idx = end_q;

endmodule

`default_nettype wire

// ----- hdl/contiguous_page_allocator_unit.sv -----
// Top level of the first-fit contiguous page allocator: sequencer, APB registers,
// output register, divider and the row of page cells.
// Depends on cpa_pkg, cpa_div and cpa_cell.
`timescale 1ns / 1ps
`default_nettype none

//  channel  | direction | handshake               | payload
//  s_*      | in        | s_tvalid / s_tready     | tuser command, tdata request fields
//  m_*      | out       | m_tvalid / m_tready     | tuser granted, tdata first_page, page_count
//  APB      | in        | psel, penable, pready=1 | page size, pages_in_use
//
// A tick item goes straight to the result step: the cells free matching pages at acceptance.
// A granted allocate item runs through 19 divider steps, a check step, one token pass
// down the cell row (one cell a cycle), then a marking step.
// An allocate item that finds no run goes from the scan straight to the result step.
// A request larger than the managed pages fails at the check step, without a scan.
// Reset frees all pages at once. A new item is taken while a result waits on m_*;
// a stalled m_tready holds the sequencer in its result step.

module contiguous_page_allocator_unit import cpa_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input items
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [71:0]        s_tdata,  // now_time, owner, memory_needed, release time
	input  wire logic               s_tuser,  // command
	// results
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [15:0]             m_tdata,  // first_page, page_count
	output logic                    m_tuser,  // granted
	// configuration
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [ADDR_W-1:0]  paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DIV   = 6'b000010,
		ST_CHECK = 6'b000100,
		ST_SCAN  = 6'b001000,
		ST_MARK  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	logic [PSIZE_W-1:0] pg_size_q;
	logic [PUSE_W-1:0]  pages_in_use_q;
	logic [PSIZE_W-1:0] psz;
	logic [CNT_W-1:0]   limit;

	logic [TIME_W-1:0]  in_now;
	logic [OWNER_W-1:0] in_owner;
	logic [BYTES_W-1:0] in_bytes;
	logic [TIME_W-1:0]  in_rel;

	logic [OWNER_W-1:0] owner_q;
	logic [TIME_W-1:0]  rel_q;
	logic [CNT_W-1:0]   need_q;
	logic [IDX_W-1:0]   first_q;
	logic [IDX_W-1:0]   last_q;
	logic               res_granted_q;

	logic               accept;
	logic               div_start;
	logic               div_done;
	logic [DVD_W-1:0]   dividend;
	logic [DVD_W-1:0]   quotient;
	logic [DVD_W-1:0]   need_raw;
	logic               need_ok;
	logic               out_load;

	cell_ctl_t          ctl;
	link_t              link [MAX_PAGES+1];

	// Unpack the request
	assign in_now   = s_tdata[15:0];
	assign in_owner = s_tdata[31:16];
	assign in_bytes = s_tdata[49:32];
	assign in_rel   = s_tdata[65:50];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Configuration registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pg_size_q      <= PG_SIZE_RST;
			pages_in_use_q <= PAGES_IN_USE_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_PG_SIZE) begin
				pg_size_q <= pwdata[PSIZE_W-1:0];
			end else begin
				pages_in_use_q <= pwdata[PUSE_W-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_PAGES_IN_USE) ?
		{{(32-PUSE_W){1'b0}}, pages_in_use_q} : {{(32-PSIZE_W){1'b0}}, pg_size_q};

	// Clamp page size and managed page count
	assign psz = (pg_size_q == '0) ? PSIZE_W'(1) : pg_size_q;
	always_comb begin
		if (32'(pages_in_use_q) > MAX_PAGES) begin
			limit = CNT_W'(MAX_PAGES);
		end else begin
			limit = CNT_W'(pages_in_use_q);
		end
	end

	// Page count: ceil(bytes / page size)
	assign div_start = accept && (s_tuser == CMD_ALLOC);
	assign dividend  = DVD_W'(in_bytes) + DVD_W'(psz) - DVD_W'(1);

	cpa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (psz),
		.done     (div_done),
		.quotient (quotient)
	);

	assign need_raw = (quotient == '0) ? DVD_W'(1) : quotient;
	assign need_ok  = (32'(need_raw) <= 32'(limit));

	// Broadcast controls
	always_comb begin
		ctl.tick_en    = accept && (s_tuser == CMD_TICK);
		ctl.now        = in_now;
		ctl.mark_en    = (state_q == ST_MARK);
		ctl.mark_first = first_q;
		ctl.mark_last  = last_q;
		ctl.owner      = owner_q;
		ctl.rel        = rel_q;
		ctl.need       = need_q;
		ctl.limit      = limit;
	end

	// Seed the scan token at the head of the row
	assign link[0].tok     = (state_q == ST_CHECK) && need_ok;
	assign link[0].run     = '0;
	assign link[0].found   = 1'b0;
	assign link[0].end_idx = '0;

	for (genvar i = 0; i < MAX_PAGES; i++) begin : g_cell
		cpa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (IDX_W'(i)),
			.ctl      (ctl),
			.link_in  (link[i]),
			.link_out (link[i+1])
		);
	end

	assign out_load = (state_q == ST_DONE) && (!m_tvalid || m_tready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			res_granted_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_granted_q <= 1'b0;
						state_q       <= (s_tuser == CMD_ALLOC) ? ST_DIV : ST_DONE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= need_ok ? ST_SCAN : ST_DONE;
				end
				ST_SCAN: begin
					if (link[MAX_PAGES].tok) begin
						state_q <= link[MAX_PAGES].found ? ST_MARK : ST_DONE;
					end
				end
				ST_MARK: begin
					res_granted_q <= 1'b1;
					state_q       <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request payload and the run bounds; hold the page count ready before the scan
	always_ff @(posedge clk) begin
		if (accept) begin
			owner_q <= in_owner;
			rel_q   <= in_rel;
		end
		if (state_q == ST_DIV && div_done) begin
			need_q <= CNT_W'(need_raw);
		end
		if (state_q == ST_SCAN && link[MAX_PAGES].tok) begin
			last_q  <= link[MAX_PAGES].end_idx;
			first_q <= IDX_W'(CNT_W'(link[MAX_PAGES].end_idx) + CNT_W'(1) - need_q);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tuser <= res_granted_q;
			m_tdata <= {3'b000,
				res_granted_q ? COUNT_W'(need_q) : COUNT_W'(0),
				res_granted_q ? FIRST_W'(first_q) : FIRST_W'(0)};
		end
	end

	// The divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider done outside the divide step");

	// The scan token leaves the row only during a scan
	a_tok_out: assert property (@(posedge clk) disable iff (!arst_n)
		link[MAX_PAGES].tok |-> state_q == ST_SCAN)
		else $error("scan token out of the row outside a scan");

	// A stalled result keeps the sequencer waiting
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && m_tvalid && !m_tready) |=> state_q == ST_DONE)
		else $error("sequencer left the result step while the output stalled");

	// A grant always reports a nonempty run
	a_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && res_granted_q) |-> need_q != '0)
		else $error("grant with an empty run");

endmodule

`default_nettype wire
